>>> design/cfv_pkg.sv
// ----------------------------------------------------------------------------
// cfv_pkg
// types and constants shared by the collector frame verifier
// ----------------------------------------------------------------------------
package cfv_pkg;

  localparam int unsigned CountWidth   = 17;
  localparam int unsigned IdWidth      = 40;
  localparam int unsigned AddrWidth    = 3;
  localparam int unsigned DataWidth    = 32;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [CountWidth-1:0] MinFrame = 17'd12;
  localparam logic [CountWidth-1:0] IdFirst  = 17'd5;
  localparam logic [CountWidth-1:0] IdLast   = 17'd9;

  // register indexes, decoded from paddr[2]
  localparam logic RegLengthPosition = 1'b0;
  localparam logic RegOverheadBytes  = 1'b1;

  localparam logic [3:0] LengthPositionReset = 4'd10;
  localparam logic [7:0] OverheadBytesReset  = 8'd14;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic               frame_ok;
    logic               checksum_ok;
    logic               length_ok;
    logic               too_short;
    logic [IdWidth-1:0] meter_id;
  } out_t;

endpackage

>>> design/collector_frame_verifier.sv
// ----------------------------------------------------------------------------
// collector_frame_verifier
// per-byte frame checker: additive checksum, length field, meter id
// ----------------------------------------------------------------------------
// Frame bytes enter on the byte channel, one beat per cycle, with last_byte
// set on the final beat. Each other beat updates the running sum, previous
// byte, saturating byte count and captured length and id bytes; the final
// beat clears them and loads the result register, giving one result beat in
// the cycle after; other beats give none. A beat is taken every cycle except
// when a final beat comes while an earlier result is held and not taken.
// The user must write configuration (length_position, overhead_bytes) over
// APB addresses 0 and 4 only while the block is idle; this is not enforced.
module collector_frame_verifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             byte_valid,
  output logic                             byte_ready,
  input  cfv_pkg::in_t                     byte_data,
  output logic                             result_valid,
  input  logic                             result_ready,
  output cfv_pkg::out_t                    result_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cfv_pkg::AddrWidth-1:0]    paddr,
  input  logic [cfv_pkg::DataWidth-1:0]    pwdata,
  output logic [cfv_pkg::DataWidth-1:0]    prdata,
  output logic                             pready
);

  logic [3:0] length_position;
  logic [7:0] overhead_bytes;

  logic [7:0]                     running_sum;
  logic [7:0]                     previous_byte;
  logic [cfv_pkg::CountWidth-1:0] byte_count;
  logic [7:0]                     length_low;
  logic [7:0]                     length_high;
  logic [cfv_pkg::IdWidth-1:0]    id_bytes;

  logic [7:0]                     length_low_next;
  logic [7:0]                     length_high_next;
  logic [cfv_pkg::IdWidth-1:0]    id_bytes_next;
  logic [cfv_pkg::CountWidth-1:0] size;
  logic [cfv_pkg::CountWidth-1:0] pos_low;
  logic [cfv_pkg::CountWidth-1:0] len_field;
  logic [cfv_pkg::CountWidth-1:0] size_diff;
  logic [2:0]                     id_slot;
  logic                           short_frame;
  logic                           cs_ok;
  logic                           len_ok;
  logic                           accept;
  logic                           cfg_write;
  cfv_pkg::out_t                  result_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      cfv_pkg::RegLengthPosition: prdata = {28'd0, length_position};
      cfv_pkg::RegOverheadBytes:  prdata = {24'd0, overhead_bytes};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_position <= cfv_pkg::LengthPositionReset;
      overhead_bytes  <= cfv_pkg::OverheadBytesReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        cfv_pkg::RegLengthPosition: length_position <= pwdata[3:0];
        cfv_pkg::RegOverheadBytes:  overhead_bytes  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // a non-final beat never needs the result register
  assign byte_ready = !result_valid || result_ready || !byte_data.last_byte;
  assign accept     = byte_valid && byte_ready;

  // captures include the current beat
  always_comb begin
    pos_low          = {13'd0, length_position};
    length_low_next  = (byte_count == pos_low) ? byte_data.data_byte : length_low;
    length_high_next = (byte_count == pos_low + 17'd1) ? byte_data.data_byte : length_high;
    id_slot          = 3'(byte_count - cfv_pkg::IdFirst);
    id_bytes_next    = id_bytes;
    if (byte_count >= cfv_pkg::IdFirst && byte_count <= cfv_pkg::IdLast) begin
      id_bytes_next[8*id_slot +: 8] = byte_data.data_byte;
    end

    size        = (byte_count < cfv_pkg::CountMax) ? byte_count + 17'd1 : cfv_pkg::CountMax;
    short_frame = size < cfv_pkg::MinFrame;
    cs_ok       = !short_frame && (8'(running_sum - previous_byte) == previous_byte);
    len_field   = {1'b0, length_high_next, length_low_next};
    size_diff   = size - {9'd0, overhead_bytes};
    len_ok      = !short_frame && (size >= {9'd0, overhead_bytes}) && (len_field == size_diff);

    result_next.frame_ok    = cs_ok && len_ok && !short_frame;
    result_next.checksum_ok = cs_ok;
    result_next.length_ok   = len_ok;
    result_next.too_short   = short_frame;
    result_next.meter_id    = id_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      previous_byte <= '0;
      byte_count    <= '0;
      length_low    <= '0;
      length_high   <= '0;
      id_bytes      <= '0;
    end else if (accept) begin
      if (byte_data.last_byte) begin
        running_sum   <= '0;
        previous_byte <= '0;
        byte_count    <= '0;
        length_low    <= '0;
        length_high   <= '0;
        id_bytes      <= '0;
      end else begin
        running_sum   <= running_sum + byte_data.data_byte;
        previous_byte <= byte_data.data_byte;
        if (byte_count < cfv_pkg::CountMax) begin
          byte_count <= byte_count + 17'd1;
        end
        length_low  <= length_low_next;
        length_high <= length_high_next;
        id_bytes    <= id_bytes_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && byte_data.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_data.last_byte) begin
      result_data <= result_next;
    end
  end

endmodule
